// File: design/mciw_pkg.sv
// Shared types and constants for the multi-channel inactivity watchdog.
`default_nettype none
package mciw_pkg;

    localparam int NumChannels = 4;
    localparam int MaxCh       = 4;
    localparam int ChIdxW      = 2;
    localparam int CntW        = 32;
    localparam int MsW         = 16;
    localparam int MaskW       = 4;
    localparam int AddrW       = 5;
    localparam int DataW       = 32;
    localparam int RegIdxW     = 3;

    localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
    localparam logic [MsW-1:0] IntervalReset = 16'd100;
    localparam logic [MsW-1:0] LimitReset = 16'd1000;

    localparam logic [RegIdxW-1:0] REG_INTERVAL_BASE = 3'd0;
    localparam logic [RegIdxW-1:0] REG_LIMIT_BASE    = 3'd4;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_ARM    = 2'd1,
        FUNC_DISARM = 2'd2
    } t_func;

    typedef struct packed {
        logic [MaxCh-1:0][MsW-1:0] interval;
        logic [MaxCh-1:0][MsW-1:0] limit;
    } t_cfg;

    typedef struct packed {
        logic tick;
        logic clear;
    } t_ch_ctrl;

endpackage
`default_nettype wire

// File: design/multi_channel_inactivity_watchdog_unit.sv
// Top level of the multi-channel inactivity watchdog.
// The unit takes one item per clock cycle while the result side is not stalled. An accepted
// item is held in the input register, and its result is loaded into the result register when
// that register is empty or its result is being taken; the four channel compare-and-add units
// between those two registers set the one-item-per-cycle rate. Backpressure on the result
// side holds the input register, and input is taken again in the same cycle as the waiting
// result is taken. Intervals and limits are written through the configuration port; the user
// must write them only while the unit is idle, as the block itself does not enforce it.
`default_nettype none
module multi_channel_inactivity_watchdog_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [1:0]                    i_func,
    input  wire logic [mciw_pkg::MsW-1:0]      i_elapsed_ms,
    input  wire logic [mciw_pkg::MaskW-1:0]    i_activity_mask,
    input  wire logic [mciw_pkg::MaskW-1:0]    i_enabled_mask,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic      [mciw_pkg::MaskW-1:0]    o_trigger_mask,
    output logic      [mciw_pkg::CntW-1:0]     o_alive_count,
    output logic                               o_armed,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mciw_pkg::AddrW-1:0]    paddr,
    input  wire logic [mciw_pkg::DataW-1:0]    pwdata,
    output logic      [mciw_pkg::DataW-1:0]    prdata,
    output logic                               pready
);

    mciw_pkg::t_cfg                  w_cfg;
    mciw_pkg::t_ch_ctrl              w_ctrl;

    logic                            r_in_valid;
    mciw_pkg::t_func                 r_func;
    logic [mciw_pkg::MsW-1:0]        r_elapsed;
    logic [mciw_pkg::MaskW-1:0]      r_act;
    logic [mciw_pkg::MaskW-1:0]      r_en;

    logic                            r_out_valid;
    logic [mciw_pkg::MaskW-1:0]      r_trig;
    logic [mciw_pkg::CntW-1:0]       r_alive;
    logic                            r_armed;

    logic                            w_advance;
    logic                            w_fire;
    logic [mciw_pkg::MaskW-1:0]      w_ch_trig;
    logic [mciw_pkg::MaskW-1:0]      n_trig;
    logic [mciw_pkg::CntW-1:0]       n_alive;
    logic                            n_armed;

    mciw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_advance = !r_out_valid || i_ready;
    assign w_fire    = r_in_valid && w_advance;
    assign o_ready   = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_func    <= mciw_pkg::t_func'(i_func);
            r_elapsed <= i_elapsed_ms;
            r_act     <= i_activity_mask;
            r_en      <= i_enabled_mask;
        end
    end

    always_comb begin
        w_ctrl.tick  = 1'b0;
        w_ctrl.clear = 1'b0;
        n_trig       = '0;
        n_alive      = r_alive;
        n_armed      = r_armed;
        case (r_func)
            mciw_pkg::FUNC_TICK: begin
                w_ctrl.tick = w_fire && r_armed;
                n_trig      = r_armed ? w_ch_trig : '0;
                n_alive     = r_alive + 1'b1;
            end
            mciw_pkg::FUNC_ARM: begin
                n_armed = 1'b1;
            end
            mciw_pkg::FUNC_DISARM: begin
                n_armed      = 1'b0;
                w_ctrl.clear = w_fire;
            end
            default: begin
            end
        endcase
    end

    for (genvar g = 0; g < mciw_pkg::MaskW; g++) begin : g_ch
        if (g < mciw_pkg::NumChannels) begin : g_used
            mciw_channel u_ch (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (w_ctrl),
                .i_elapsed  (r_elapsed),
                .i_active   (r_act[g]),
                .i_enabled  (r_en[g]),
                .i_interval (w_cfg.interval[g]),
                .i_limit    (w_cfg.limit[g]),
                .o_trigger  (w_ch_trig[g])
            );
        end else begin : g_unused
            assign w_ch_trig[g] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_alive     <= '0;
            r_armed     <= 1'b0;
        end else begin
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_alive <= n_alive;
                r_armed <= n_armed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_trig <= n_trig;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_trigger_mask = r_trig;
    assign o_alive_count  = r_alive;
    assign o_armed        = r_armed;

endmodule
`default_nettype wire

// File: design/mciw_regs.sv
// APB-style configuration registers for the watchdog intervals and limits.
`default_nettype none
module mciw_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mciw_pkg::AddrW-1:0]    paddr,
    input  wire logic [mciw_pkg::DataW-1:0]    pwdata,
    output logic      [mciw_pkg::DataW-1:0]    prdata,
    output logic                               pready,
    output mciw_pkg::t_cfg                     o_cfg
);

    mciw_pkg::t_cfg                  r_cfg;
    logic [mciw_pkg::RegIdxW-1:0]    w_idx;
    logic [mciw_pkg::ChIdxW-1:0]     w_ch;
    logic                            w_wr;

    assign w_idx  = paddr[mciw_pkg::AddrW-1:2];
    assign w_ch   = w_idx[mciw_pkg::ChIdxW-1:0];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mciw_pkg::MaxCh; i++) begin
                r_cfg.interval[i] <= mciw_pkg::IntervalReset;
                r_cfg.limit[i]    <= mciw_pkg::LimitReset;
            end
        end else if (w_wr) begin
            if (w_idx < mciw_pkg::REG_LIMIT_BASE) begin
                r_cfg.interval[w_ch] <= pwdata[mciw_pkg::MsW-1:0];
            end else begin
                r_cfg.limit[w_ch] <= pwdata[mciw_pkg::MsW-1:0];
            end
        end
    end

    always_comb begin
        if (w_idx < mciw_pkg::REG_LIMIT_BASE) begin
            prdata = {{(mciw_pkg::DataW - mciw_pkg::MsW){1'b0}}, r_cfg.interval[w_ch]};
        end else begin
            prdata = {{(mciw_pkg::DataW - mciw_pkg::MsW){1'b0}}, r_cfg.limit[w_ch]};
        end
    end

endmodule
`default_nettype wire

// File: design/mciw_channel.sv
// One channel: saturating inactivity counter with interval check and trigger.
`default_nettype none
module mciw_channel (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire mciw_pkg::t_ch_ctrl           i_ctrl,
    input  wire logic [mciw_pkg::MsW-1:0]     i_elapsed,
    input  wire logic                         i_active,
    input  wire logic                         i_enabled,
    input  wire logic [mciw_pkg::MsW-1:0]     i_interval,
    input  wire logic [mciw_pkg::MsW-1:0]     i_limit,
    output logic                              o_trigger
);

    logic [mciw_pkg::CntW-1:0] r_count;
    logic [mciw_pkg::CntW-1:0] n_count;
    logic [mciw_pkg::CntW:0]   w_sum;
    logic [mciw_pkg::CntW-1:0] w_sat;
    logic                      w_checked;

    assign w_sum = {1'b0, r_count}
                 + {{(mciw_pkg::CntW + 1 - mciw_pkg::MsW){1'b0}}, i_elapsed};
    assign w_sat = w_sum[mciw_pkg::CntW] ? mciw_pkg::CntMax : w_sum[mciw_pkg::CntW-1:0];
    assign w_checked = r_count > {{(mciw_pkg::CntW - mciw_pkg::MsW){1'b0}}, i_interval};

    always_comb begin
        o_trigger = 1'b0;
        if (w_checked) begin
            if (i_active || !i_enabled) begin
                n_count = '0;
            end else begin
                n_count   = w_sat;
                o_trigger = w_sat > {{(mciw_pkg::CntW - mciw_pkg::MsW){1'b0}}, i_limit};
            end
        end else begin
            n_count = w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctrl.clear) begin
            r_count <= '0;
        end else if (i_ctrl.tick) begin
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

// File: test/tb_multi_channel_inactivity_watchdog_unit.sv
// Self-checking testbench for the multi-channel inactivity watchdog unit.
module tb_multi_channel_inactivity_watchdog_unit;

    localparam logic [1:0] FuncUnused = 2'd3;
    localparam int NumRegs = 8;
    localparam int PhaseItems = 65;

    typedef struct packed {
        logic [mciw_pkg::MaskW-1:0] trigger_mask;
        logic [mciw_pkg::CntW-1:0]  alive_count;
        logic                       armed;
    } t_tick_outcome;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_ready;
    logic [1:0]                     i_func;
    logic [mciw_pkg::MsW-1:0]       i_elapsed_ms;
    logic [mciw_pkg::MaskW-1:0]     i_activity_mask;
    logic [mciw_pkg::MaskW-1:0]     i_enabled_mask;
    logic                           o_valid;
    logic                           i_ready;
    logic [mciw_pkg::MaskW-1:0]     o_trigger_mask;
    logic [mciw_pkg::CntW-1:0]      o_alive_count;
    logic                           o_armed;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [mciw_pkg::AddrW-1:0]     paddr;
    logic [mciw_pkg::DataW-1:0]     pwdata;
    logic [mciw_pkg::DataW-1:0]     prdata;
    logic                           pready;

    logic [mciw_pkg::CntW-1:0]      cnt_ms [mciw_pkg::NumChannels];
    logic [mciw_pkg::MsW-1:0]       interval_ms [mciw_pkg::NumChannels];
    logic [mciw_pkg::MsW-1:0]       limit_ms [mciw_pkg::NumChannels];
    logic                           is_armed;
    logic [mciw_pkg::CntW-1:0]      beats;

    t_tick_outcome                  outcomes_due [$];
    int                             failures;
    bit                             gap_enable;
    bit                             stall_enable;

    multi_channel_inactivity_watchdog_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_elapsed_ms    (i_elapsed_ms),
        .i_activity_mask (i_activity_mask),
        .i_enabled_mask  (i_enabled_mask),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_trigger_mask  (o_trigger_mask),
        .o_alive_count   (o_alive_count),
        .o_armed         (o_armed),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic void reset_watchdog_model();
        for (int ch = 0; ch < mciw_pkg::NumChannels; ch++) begin
            cnt_ms[ch] = '0;
            interval_ms[ch] = mciw_pkg::IntervalReset;
            limit_ms[ch] = mciw_pkg::LimitReset;
        end
        is_armed = 1'b0;
        beats = '0;
    endfunction

    function automatic t_tick_outcome run_watchdog_item(
        input logic [1:0] code,
        input logic [mciw_pkg::MsW-1:0] elapsed,
        input logic [mciw_pkg::MaskW-1:0] act,
        input logic [mciw_pkg::MaskW-1:0] en);
        t_tick_outcome res;
        logic [mciw_pkg::CntW:0] sum;
        logic due;
        res.trigger_mask = '0;
        case (code)
            mciw_pkg::FUNC_TICK: begin
                if (is_armed) begin
                    for (int ch = 0; ch < mciw_pkg::NumChannels; ch++) begin
                        due = cnt_ms[ch] > interval_ms[ch];
                        if (due && (act[ch] || !en[ch])) begin
                            cnt_ms[ch] = '0;
                        end else begin
                            sum = {1'b0, cnt_ms[ch]} + elapsed;
                            cnt_ms[ch] = sum[mciw_pkg::CntW] ? mciw_pkg::CntMax
                                                             : sum[mciw_pkg::CntW-1:0];
                            if (due && cnt_ms[ch] > limit_ms[ch]) begin
                                res.trigger_mask[ch] = 1'b1;
                            end
                        end
                    end
                end
                beats = beats + 1'b1;
            end
            mciw_pkg::FUNC_ARM: begin
                is_armed = 1'b1;
            end
            mciw_pkg::FUNC_DISARM: begin
                is_armed = 1'b0;
                for (int ch = 0; ch < mciw_pkg::NumChannels; ch++) begin
                    cnt_ms[ch] = '0;
                end
            end
            default: begin
            end
        endcase
        res.alive_count = beats;
        res.armed = is_armed;
        return res;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input logic [1:0] code, input logic [mciw_pkg::MsW-1:0] elapsed,
                             input logic [mciw_pkg::MaskW-1:0] act,
                             input logic [mciw_pkg::MaskW-1:0] en);
        int gap;
        t_tick_outcome expected;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_func <= code;
        i_elapsed_ms <= elapsed;
        i_activity_mask <= act;
        i_enabled_mask <= en;
        do @(posedge i_clk); while (!o_ready);
        expected = run_watchdog_item(code, elapsed, act, en);
        outcomes_due = {outcomes_due, expected};
        gap = gap_enable ? idle_len() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input int idx, input logic [mciw_pkg::MsW-1:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= mciw_pkg::AddrW'(4 * idx);
        pwdata <= mciw_pkg::DataW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx < int'(mciw_pkg::REG_LIMIT_BASE)) begin
            interval_ms[idx - int'(mciw_pkg::REG_INTERVAL_BASE)] = value;
        end else begin
            limit_ms[idx - int'(mciw_pkg::REG_LIMIT_BASE)] = value;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_reg(input int idx);
        logic [mciw_pkg::MsW-1:0] want;
        if (idx < int'(mciw_pkg::REG_LIMIT_BASE)) begin
            want = interval_ms[idx - int'(mciw_pkg::REG_INTERVAL_BASE)];
        end else begin
            want = limit_ms[idx - int'(mciw_pkg::REG_LIMIT_BASE)];
        end
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        penable <= 1'b0;
        paddr <= mciw_pkg::AddrW'(4 * idx);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== mciw_pkg::DataW'(want)) begin
            $error("prdata: register %0d expected %h, got %h", idx,
                   mciw_pkg::DataW'(want), prdata);
            failures++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_channel(input int ch, input logic [mciw_pkg::MsW-1:0] iv,
                                   input logic [mciw_pkg::MsW-1:0] lim);
        write_reg(int'(mciw_pkg::REG_INTERVAL_BASE) + ch, iv);
        write_reg(int'(mciw_pkg::REG_LIMIT_BASE) + ch, lim);
        check_reg(int'(mciw_pkg::REG_INTERVAL_BASE) + ch);
        check_reg(int'(mciw_pkg::REG_LIMIT_BASE) + ch);
    endtask

    task automatic send_random_item();
        logic [1:0] code;
        logic [mciw_pkg::MsW-1:0] elapsed;
        logic [mciw_pkg::MaskW-1:0] act;
        logic [mciw_pkg::MaskW-1:0] en;
        int r;
        r = $urandom_range(0, 99);
        if (r < 82) begin
            code = mciw_pkg::FUNC_TICK;
        end else if (r < 89) begin
            code = mciw_pkg::FUNC_ARM;
        end else if (r < 95) begin
            code = mciw_pkg::FUNC_DISARM;
        end else begin
            code = FuncUnused;
        end
        r = $urandom_range(0, 99);
        if (r < 10) begin
            elapsed = '0;
        end else if (r < 15) begin
            elapsed = '1;
        end else if (r < 25) begin
            elapsed = mciw_pkg::MsW'($urandom);
        end else begin
            elapsed = mciw_pkg::MsW'($urandom_range(0, 400));
        end
        act = ($urandom_range(0, 99) < 60) ? '0 : mciw_pkg::MaskW'($urandom);
        en = ($urandom_range(0, 99) < 70) ? '1 : mciw_pkg::MaskW'($urandom);
        send_item(code, elapsed, act, en);
    endtask

    task automatic test_register_reset_values();
        for (int idx = 0; idx < NumRegs; idx++) begin
            check_reg(idx);
        end
    endtask

    task automatic test_directed_items();
        send_item(FuncUnused, '1, '1, '1);
        send_item(mciw_pkg::FUNC_TICK, '1, '0, '1);
        send_item(mciw_pkg::FUNC_DISARM, '0, '0, '0);
        send_item(mciw_pkg::FUNC_ARM, '0, '0, '0);
        send_item(mciw_pkg::FUNC_ARM, '1, '1, '1);
        send_item(mciw_pkg::FUNC_TICK, '0, '0, '1);
        send_item(mciw_pkg::FUNC_TICK, 16'd150, '0, '1);
        send_item(mciw_pkg::FUNC_TICK, '1, '0, '1);
        send_item(mciw_pkg::FUNC_TICK, '0, '0, '1);
        send_item(mciw_pkg::FUNC_TICK, 16'd1, 4'h5, '1);
        send_item(mciw_pkg::FUNC_TICK, 16'd1, '0, 4'h3);
        send_item(mciw_pkg::FUNC_TICK, 16'd200, 4'hA, 4'h6);
        send_item(FuncUnused, '0, '0, '0);
        send_item(mciw_pkg::FUNC_DISARM, '1, '1, '1);
        send_item(mciw_pkg::FUNC_TICK, '1, '0, '1);
        send_item(mciw_pkg::FUNC_ARM, '0, '0, '0);
        send_item(mciw_pkg::FUNC_TICK, '1, '0, '1);
        send_item(mciw_pkg::FUNC_TICK, 16'd1, '0, '1);
        send_item(mciw_pkg::FUNC_TICK, 16'd1, 4'hF, 4'h0);
        send_item(mciw_pkg::FUNC_DISARM, '0, '0, '0);
        wait_idle();
    endtask

    task automatic test_random_phases();
        logic [mciw_pkg::MsW-1:0] iv;
        logic [mciw_pkg::MsW-1:0] lim;
        for (int phase = 0; phase < 6; phase++) begin
            for (int ch = 0; ch < mciw_pkg::NumChannels; ch++) begin
                if (phase == 0) begin
                    iv = '0;
                    lim = '0;
                end else if (phase == 1) begin
                    iv = '1;
                    lim = '1;
                end else if (phase == 2) begin
                    iv = mciw_pkg::IntervalReset;
                    lim = mciw_pkg::LimitReset;
                end else if ($urandom_range(0, 3) == 0) begin
                    iv = mciw_pkg::MsW'($urandom);
                    lim = mciw_pkg::MsW'($urandom);
                end else begin
                    iv = mciw_pkg::MsW'($urandom_range(0, 300));
                    lim = mciw_pkg::MsW'($urandom_range(0, 3000));
                end
                program_channel(ch, iv, lim);
            end
            gap_enable = (phase != 3);
            stall_enable = (phase != 3);
            send_item(mciw_pkg::FUNC_ARM, '0, '0, '0);
            for (int n = 0; n < PhaseItems; n++) begin
                send_random_item();
            end
            wait_idle();
        end
        gap_enable = 1'b1;
        stall_enable = 1'b1;
    endtask

    initial begin
        int run;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            i_ready <= 1'b1;
            run = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 6) : $urandom_range(20, 60);
            repeat (run) @(negedge i_clk);
            if (stall_enable) begin
                i_ready <= 1'b0;
                if ($urandom_range(0, 99) < 85) begin
                    repeat ($urandom_range(1, 3)) @(negedge i_clk);
                end else begin
                    repeat ($urandom_range(8, 40)) @(negedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_tick_outcome want;
        if (i_rst_n && o_valid && i_ready) begin
            if (outcomes_due.size() == 0) begin
                $error("result transfer with no item outstanding");
                failures++;
            end else begin
                want = outcomes_due.pop_front();
                if (o_trigger_mask !== want.trigger_mask) begin
                    $error("trigger_mask: expected %h, got %h", want.trigger_mask,
                           o_trigger_mask);
                    failures++;
                end
                if (o_alive_count !== want.alive_count) begin
                    $error("alive_count: expected %h, got %h", want.alive_count,
                           o_alive_count);
                    failures++;
                end
                if (o_armed !== want.armed) begin
                    $error("armed: expected %b, got %b", want.armed, o_armed);
                    failures++;
                end
            end
        end
    end

    initial begin
        failures = 0;
        gap_enable = 1'b1;
        stall_enable = 1'b1;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = mciw_pkg::FUNC_TICK;
        i_elapsed_ms = '0;
        i_activity_mask = '0;
        i_enabled_mask = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        reset_watchdog_model();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_register_reset_values();
        test_directed_items();
        test_random_phases();

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/mciw_pkg.sv
design/mciw_regs.sv
design/mciw_channel.sv
design/multi_channel_inactivity_watchdog_unit.sv
test/tb_multi_channel_inactivity_watchdog_unit.sv
